@@ hdl/ndc_pkg.sv @@
`timescale 1ns / 1ps
package ndc_pkg;

  // conversion modes
  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_BIN  = 2'd3;

  // digit limits per mode
  localparam logic [5:0] MAX_DEC_DIGITS = 6'd10;
  localparam logic [5:0] MAX_HEX_DIGITS = 6'd8;
  localparam logic [5:0] MAX_BIN_DIGITS = 6'd32;

  // digit buffer: ten bcd nibbles, also holds eight hex nibbles or 32 bits
  localparam int unsigned DIG_BITS = 40;
  localparam logic [5:0] NIB_SLOTS = 6'd10;
  localparam logic [5:0] BIT_SLOTS = 6'd40;

  // ascii codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  typedef logic [6:0] char_t;

endpackage

@@ hdl/ndc_if.sv @@
`timescale 1ns / 1ps
interface ndc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] number;
  logic [5:0]  digit_count;
  logic [2:0]  text_line;
  logic [4:0]  start_column;

  modport source (output valid, mode, number, digit_count, text_line, start_column,
                  input ready);
  modport sink   (input valid, mode, number, digit_count, text_line, start_column,
                  output ready);
endinterface

interface ndc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic [2:0] out_line;
  logic [5:0] out_column;
  logic       last_char;

  modport source (output valid, character, out_line, out_column, last_char,
                  input ready);
  modport sink   (input valid, character, out_line, out_column, last_char,
                  output ready);
endinterface

@@ hdl/number_to_digit_characters_core.sv @@
`timescale 1ns / 1ps
// number to ascii digit characters
//
// in_chan carries one number with its mode (unsigned decimal, signed
// decimal, hex, binary), digit count, text line and start column. out_chan
// carries one ascii character per item, most significant first, with its
// line and column; last_char marks the final character of the number.
// signed decimal sends '+' or '-' ahead of the digits.
//
// one number is in work at a time. decimal first runs a bit-serial double-dabble
// over all NUMBER_WIDTH source bits; every mode then shifts the first digit to
// the top of the digit buffer (10 slots for nibbles, 40 for bits), then sends
// one character per cycle while out_chan does not stall.
//
// reset (synchronous, rst_n low) empties the output register and returns
// to idle. when out_chan stalls the pending character holds and the
// sequencer waits; in_chan takes a new number only once the previous one
// has handed over all its characters to the output register.
module number_to_digit_characters_core #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  ndc_in_if.sink    in_chan,
  ndc_out_if.source out_chan
);
  import ndc_pkg::*;

  localparam int W  = NUMBER_WIDTH;
  localparam int CW = $clog2(W + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CONV  = 2'd1;
  localparam logic [1:0] S_ALIGN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [DIG_BITS-1:0] digs_r, digs_nxt;
  logic [W-1:0]        shf_r, shf_nxt;
  logic [CW-1:0]       bitcnt_r, bitcnt_nxt;
  logic [5:0]          align_r, align_nxt;
  logic [5:0]          rem_r, rem_nxt;
  logic                sign_pend_r, sign_pend_nxt;
  logic                neg_r, neg_nxt;
  logic [2:0]          line_r, line_nxt;
  logic [5:0]          col_r, col_nxt;

  logic                ovalid_r, ovalid_nxt;
  char_t               ochar_r, ochar_nxt;
  logic [2:0]          oline_r, oline_nxt;
  logic [5:0]          ocol_r, ocol_nxt;
  logic                olast_r, olast_nxt;

  logic                in_fire;
  logic                slot_free;
  logic [W-1:0]        val_in;
  logic [W-1:0]        mag_in;
  logic                neg_in;
  logic [5:0]          limit_in;
  logic [5:0]          count_in;
  logic [DIG_BITS-1:0] dabble;
  logic [3:0]          top_dig;
  char_t               dig_char;

  assign in_chan.ready = rst_n && (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign slot_free     = !ovalid_r || out_chan.ready;

  // magnitude of the incoming value, only the low NUMBER_WIDTH bits count
  assign val_in = W'(in_chan.number);
  assign neg_in = (in_chan.mode == MODE_SDEC) && val_in[W-1];
  assign mag_in = neg_in ? (~val_in + 1'b1) : val_in;

  // clamp digit count per mode
  always_comb begin
    case (in_chan.mode)
      MODE_HEX: limit_in = MAX_HEX_DIGITS;
      MODE_BIN: limit_in = MAX_BIN_DIGITS;
      default:  limit_in = MAX_DEC_DIGITS;
    endcase
    count_in = (in_chan.digit_count > limit_in) ? limit_in : in_chan.digit_count;
  end

  // double-dabble step: add 3 to every bcd digit at or above 5
  always_comb begin
    logic [3:0] d;
    for (int k = 0; k < 10; k++) begin
      d = digs_r[4*k +: 4];
      dabble[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // character for the digit at the top of the buffer
  always_comb begin
    top_dig  = (mode_r == MODE_BIN) ? {3'b000, digs_r[DIG_BITS-1]}
                                    : digs_r[DIG_BITS-1 -: 4];
    dig_char = (top_dig < 4'd10) ? CHAR_ZERO + 7'(top_dig)
                                 : CHAR_A + 7'(top_dig - 4'd10);
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    digs_nxt      = digs_r;
    shf_nxt       = shf_r;
    bitcnt_nxt    = bitcnt_r;
    align_nxt     = align_r;
    rem_nxt       = rem_r;
    sign_pend_nxt = sign_pend_r;
    neg_nxt       = neg_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    ovalid_nxt    = ovalid_r && !out_chan.ready;
    ochar_nxt     = ochar_r;
    oline_nxt     = oline_r;
    ocol_nxt      = ocol_r;
    olast_nxt     = olast_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt      = in_chan.mode;
          rem_nxt       = count_in;
          sign_pend_nxt = (in_chan.mode == MODE_SDEC);
          neg_nxt       = neg_in;
          line_nxt      = in_chan.text_line;
          col_nxt       = {1'b0, in_chan.start_column};
          align_nxt     = ((in_chan.mode == MODE_BIN) ? BIT_SLOTS : NIB_SLOTS) - count_in;
          shf_nxt       = mag_in;
          bitcnt_nxt    = CW'(W);
          if (in_chan.mode == MODE_UDEC || in_chan.mode == MODE_SDEC) begin
            digs_nxt  = '0;
            state_nxt = S_CONV;
          end else begin
            digs_nxt  = DIG_BITS'(mag_in);
            state_nxt = S_ALIGN;
          end
        end
      end
      S_CONV: begin
        // one source bit a cycle, msb first; top digit carry drops (mod 10^10)
        digs_nxt   = {dabble[DIG_BITS-2:0], shf_r[W-1]};
        shf_nxt    = shf_r << 1;
        bitcnt_nxt = bitcnt_r - 1'b1;
        if (bitcnt_r == CW'(1)) state_nxt = S_ALIGN;
      end
      S_ALIGN: begin
        // bring the first digit to emit to the top of the buffer
        if (align_r == 6'd0) begin
          state_nxt = S_EMIT;
        end else begin
          digs_nxt  = (mode_r == MODE_BIN) ? digs_r << 1 : digs_r << 4;
          align_nxt = align_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (!sign_pend_r && rem_r == 6'd0) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          ovalid_nxt = 1'b1;
          oline_nxt  = line_r;
          ocol_nxt   = col_r;
          col_nxt    = col_r + 1'b1;
          if (sign_pend_r) begin
            ochar_nxt     = neg_r ? CHAR_MINUS : CHAR_PLUS;
            olast_nxt     = (rem_r == 6'd0);
            sign_pend_nxt = 1'b0;
          end else begin
            ochar_nxt = dig_char;
            olast_nxt = (rem_r == 6'd1);
            rem_nxt   = rem_r - 1'b1;
            digs_nxt  = (mode_r == MODE_BIN) ? digs_r << 1 : digs_r << 4;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ovalid_r    <= 1'b0;
      sign_pend_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ovalid_r    <= ovalid_nxt;
      sign_pend_r <= sign_pend_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    digs_r   <= digs_nxt;
    shf_r    <= shf_nxt;
    bitcnt_r <= bitcnt_nxt;
    align_r  <= align_nxt;
    neg_r    <= neg_nxt;
    line_r   <= line_nxt;
    col_r    <= col_nxt;
    ochar_r  <= ochar_nxt;
    oline_r  <= oline_nxt;
    ocol_r   <= ocol_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_chan.valid      = ovalid_r;
  assign out_chan.character  = ochar_r;
  assign out_chan.out_line   = oline_r;
  assign out_chan.out_column = ocol_r;
  assign out_chan.last_char  = olast_r;

endmodule

@@ hdl/ndc_checker.sv @@
`timescale 1ns / 1ps
module ndc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] character,
  input logic [5:0] out_column,
  input logic       last_char
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(out_column)
      && $stable(last_char))
    else $error("stalled output item changed");

  // one number at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while busy");

  // no new number while the current one still has characters to send
  a_busy_mid_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_char |-> !in_ready)
    else $error("input ready in the middle of a number");

  // characters of a number follow without gaps once taken
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_char |=> out_valid)
    else $error("gap inside a number");

endmodule

bind number_to_digit_characters_core ndc_checker u_ndc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .character  (out_chan.character),
  .out_column (out_chan.out_column),
  .last_char  (out_chan.last_char)
);
